@@ rtl/core/dudc_pkg.sv @@
// Shared constants, result type and seven-segment table for the debounced counter.
`default_nettype none
package dudc_pkg;

  localparam int unsigned NUM_BTN   = 3;
  localparam int unsigned AGE_WIDTH = 8;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned TENS_W    = 3;
  localparam int unsigned ONES_W    = 4;
  localparam int unsigned SEG_W     = 7;
  // common width for comparing an age with the debounce setting
  localparam int unsigned CMP_W     = (AGE_WIDTH > CFG_W) ? AGE_WIDTH : CFG_W;

  localparam int unsigned BTN_UP    = 0;
  localparam int unsigned BTN_DOWN  = 1;
  localparam int unsigned BTN_CLR   = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(59);
  localparam logic [CNT_W-1:0] COUNT_RST   = CNT_W'(11);
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(10);

  typedef struct packed {
    logic [CNT_W-1:0]  count_value;
    logic [TENS_W-1:0] tens_digit;
    logic [ONES_W-1:0] ones_digit;
    logic [SEG_W-1:0]  tens_segments;
    logic [SEG_W-1:0]  ones_segments;
  } dudc_result_t;

  // gfedcba, 1 lights a segment
  function automatic logic [SEG_W-1:0] seg7(input logic [ONES_W-1:0] digit);
    logic [SEG_W-1:0] seg;
    case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h67;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/dudc_lane.sv @@
// One button debouncer: last level, saturating stable age and pressed flag.
`default_nettype none
module dudc_lane (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic                       level_i,
  input  wire logic [dudc_pkg::CFG_W-1:0] debounce_ticks_i,
  output logic                            fire_o
);
  import dudc_pkg::*;

  logic                 last_q, last_d;
  logic [AGE_WIDTH-1:0] age_q, age_d;
  logic                 flag_q, flag_d;
  logic                 hit;

  always_comb begin
    last_d = last_q;
    age_d  = age_q;
    flag_d = flag_q;
    if (level_i != last_q) begin
      last_d = level_i;
      age_d  = '0;
    end else if (age_q != '1) begin
      age_d = age_q + AGE_WIDTH'(1);
    end
    hit    = CMP_W'(age_d) >= CMP_W'(debounce_ticks_i);
    fire_o = hit && !flag_q && !level_i;
    if (hit && !flag_q && !level_i) begin
      flag_d = 1'b1;
    end else if (hit && flag_q && level_i) begin
      flag_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b1;
      age_q  <= '0;
      flag_q <= 1'b0;
    end else if (step_i) begin
      last_q <= last_d;
      age_q  <= age_d;
      flag_q <= flag_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/dudc_merge.sv @@
// Merges the lane events into the count and forms the displayed result.
`default_nettype none
module dudc_merge (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic [dudc_pkg::NUM_BTN-1:0] fire_i,
  output dudc_pkg::dudc_result_t            result_o
);
  import dudc_pkg::*;

  logic [CNT_W-1:0]   count_q, count_d;
  logic signed [CNT_W+1:0] sum;
  logic [CNT_W+3:0]   prod;
  logic [TENS_W-1:0]  tens;
  logic [ONES_W-1:0]  ones;

  always_comb begin
    sum = $signed({2'b00, count_q});
    if (fire_i[BTN_UP]) begin
      sum = sum + 8'sd1;
    end
    if (fire_i[BTN_DOWN]) begin
      sum = sum - 8'sd1;
    end
    if (fire_i[BTN_CLR]) begin
      sum = '0;
    end
    if (sum < 0 || sum > $signed({2'b00, COUNT_MAX})) begin
      count_d = '0;
    end else begin
      count_d = sum[CNT_W-1:0];
    end
  end

  // divide by ten as multiply by 13 and shift by 7, exact for 0..59
  always_comb begin
    prod = {4'b0000, count_q} * (CNT_W+4)'(13);
    tens = prod[TENS_W+6:7];
    ones = ONES_W'(count_q - CNT_W'({tens, 3'b000}) - CNT_W'({tens, 1'b0}));
    result_o.count_value   = count_q;
    result_o.tens_digit    = tens;
    result_o.ones_digit    = ones;
    result_o.tens_segments = seg7(ONES_W'(tens));
    result_o.ones_segments = seg7(ones);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RST;
    end else if (step_i) begin
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/debounced_updown_counter_7seg_top.sv @@
// Top level: three debounce lanes, count merge, two-entry output buffer.
//
// Input channel in_valid_i/in_ready_o carries one tick per beat: raw_buttons_i
// holds three active-low buttons (bit0 up, bit1 down, bit2 clear).
// Output channel out_valid_o/out_ready_i returns one beat per tick with the
// count as it stood before that tick, its two digits and segment codes.
// Config channel cfg_valid_i/cfg_ready_o writes debounce_ticks; always ready.
// A result is registered in the output register, or in the skid entry while the receiver stalls.
// Throughput: one tick per cycle while in_ready_o is high; the three lanes and the count update all
// run in the accept cycle, and an output register plus a skid entry keep
// ticks flowing while the receiver takes results.
// Receiver stall: up to two results are held; in_ready_o drops only when both
// are full and rises again as soon as one is taken.
// Reset: count 11, all buttons released with age 0 and flag clear,
// debounce_ticks 10, no result pending.
`default_nettype none
module debounced_updown_counter_7seg_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [2:0]                   raw_buttons_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [dudc_pkg::CNT_W-1:0]        count_value_o,
  output logic [dudc_pkg::TENS_W-1:0]       tens_digit_o,
  output logic [dudc_pkg::ONES_W-1:0]       ones_digit_o,
  output logic [dudc_pkg::SEG_W-1:0]        tens_segments_o,
  output logic [dudc_pkg::SEG_W-1:0]        ones_segments_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [dudc_pkg::CFG_W-1:0]   cfg_data_i
);
  import dudc_pkg::*;

  logic [CFG_W-1:0]   debounce_ticks_q;
  logic [NUM_BTN-1:0] fire;
  logic               in_acc, out_fire;
  dudc_result_t       result;
  dudc_result_t       out_q, out_d, skid_q, skid_d;
  logic               out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= DEBOUNCE_RST;
    end else if (cfg_valid_i) begin
      debounce_ticks_q <= cfg_data_i;
    end
  end

  for (genvar b = 0; b < NUM_BTN; b++) begin : g_lane
    dudc_lane u_lane (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .step_i           (in_acc),
      .level_i          (raw_buttons_i[b]),
      .debounce_ticks_i (debounce_ticks_q),
      .fire_o           (fire[b])
    );
  end

  dudc_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_acc),
    .fire_i   (fire),
    .result_o (result)
  );

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = result;
        out_valid_d = in_acc;
      end
    end else if (in_acc) begin
      skid_d       = result;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o     = out_valid_q;
  assign count_value_o   = out_q.count_value;
  assign tens_digit_o    = out_q.tens_digit;
  assign ones_digit_o    = out_q.ones_digit;
  assign tens_segments_o = out_q.tens_segments;
  assign ones_segments_o = out_q.ones_segments;

  // a held skid beat always sits behind a valid output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(skid_valid_q && !out_valid_q))
    else $error("skid entry valid with output register empty");

  // an accepted tick always leaves a result pending next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted tick produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_value_o <= COUNT_MAX))
    else $error("count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((CNT_W+1)'(tens_digit_o) * (CNT_W+1)'(10) + (CNT_W+1)'(ones_digit_o)
                     == (CNT_W+1)'(count_value_o)))
    else $error("digits disagree with count");

endmodule
`default_nettype wire
